>>> rtl/rabb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rabb_pkg
// Shared types and constants for the rotated bounding box build and overlap
// core.
// ----------------------------------------------------------------------------
package rabb_pkg;

   localparam int PT_W           = 16;
   localparam int ROT_W          = 16;
   localparam int PROD_W         = PT_W + ROT_W;
   localparam int SUM_W          = PROD_W + 1;
   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;
   localparam int CSR_ADDR_W     = 5;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_IDX_W      = 3;

   localparam logic signed [ROT_W-1:0] ROT_ONE = 16'sd16384;

   typedef enum logic {
      KIND_POINT = 1'b0,
      KIND_QUERY = 1'b1
   } item_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROT_00 = 3'd0,
      REG_ROT_01 = 3'd1,
      REG_ROT_10 = 3'd2,
      REG_ROT_11 = 3'd3,
      REG_POS_X  = 3'd4,
      REG_POS_Y  = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic          valid;
      item_kind_type kind;
      logic          last;
   } pipe_ctl_type;

endpackage
`default_nettype wire

>>> rtl/rabb_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rabb_csr
// Register file: rotation matrix and world offset, written and read over the
// APB-style port.
// ----------------------------------------------------------------------------
module rabb_csr import rabb_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [CSR_DATA_W-1:0]        csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready,
   output logic signed [ROT_W-1:0]      rot_00,
   output logic signed [ROT_W-1:0]      rot_01,
   output logic signed [ROT_W-1:0]      rot_10,
   output logic signed [ROT_W-1:0]      rot_11,
   output logic signed [PT_W-1:0]       pos_x,
   output logic signed [PT_W-1:0]       pos_y
);

   logic signed [ROT_W-1:0] rot_00_ff, rot_01_ff, rot_10_ff, rot_11_ff;
   logic signed [PT_W-1:0]  pos_x_ff, pos_y_ff;
   logic                    wr_en;
   csr_reg_type             reg_idx;
   logic [ROT_W-1:0]        rd_val;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_00_ff <= ROT_ONE;
         rot_01_ff <= '0;
         rot_10_ff <= '0;
         rot_11_ff <= ROT_ONE;
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_ROT_00: rot_00_ff <= csr_pwdata[ROT_W-1:0];
            REG_ROT_01: rot_01_ff <= csr_pwdata[ROT_W-1:0];
            REG_ROT_10: rot_10_ff <= csr_pwdata[ROT_W-1:0];
            REG_ROT_11: rot_11_ff <= csr_pwdata[ROT_W-1:0];
            REG_POS_X:  pos_x_ff  <= csr_pwdata[PT_W-1:0];
            REG_POS_Y:  pos_y_ff  <= csr_pwdata[PT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_ROT_00: rd_val = rot_00_ff;
         REG_ROT_01: rd_val = rot_01_ff;
         REG_ROT_10: rd_val = rot_10_ff;
         REG_ROT_11: rd_val = rot_11_ff;
         REG_POS_X:  rd_val = pos_x_ff;
         REG_POS_Y:  rd_val = pos_y_ff;
         default:    rd_val = '0;
      endcase
   end

   assign csr_prdata = {{(CSR_DATA_W-ROT_W){1'b0}}, rd_val};

   assign rot_00 = rot_00_ff;
   assign rot_01 = rot_01_ff;
   assign rot_10 = rot_10_ff;
   assign rot_11 = rot_11_ff;
   assign pos_x  = pos_x_ff;
   assign pos_y  = pos_y_ff;

endmodule
`default_nettype wire

>>> rtl/rabb_rotate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rabb_rotate
// Input register: takes a beat and forms the four matrix-by-point products
// from the registered point.
// ----------------------------------------------------------------------------
module rabb_rotate import rabb_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int OTH_W     = 4 * (COORD_BITS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  item_kind_type            in_kind,
   input  logic                     in_last,
   input  logic signed [PT_W-1:0]   in_pt_x,
   input  logic signed [PT_W-1:0]   in_pt_y,
   input  logic [OTH_W-1:0]         in_other,
   input  logic signed [ROT_W-1:0]  rot_00,
   input  logic signed [ROT_W-1:0]  rot_01,
   input  logic signed [ROT_W-1:0]  rot_10,
   input  logic signed [ROT_W-1:0]  rot_11,
   input  logic                     prod_ready,
   output pipe_ctl_type             prod_ctl,
   output logic signed [PROD_W-1:0] prod_00,
   output logic signed [PROD_W-1:0] prod_01,
   output logic signed [PROD_W-1:0] prod_10,
   output logic signed [PROD_W-1:0] prod_11,
   output logic [OTH_W-1:0]         prod_other
);

   pipe_ctl_type            s1_ctl_ff, s1_ctl_in;
   logic signed [PT_W-1:0]  pt_x_ff, pt_y_ff;
   logic [OTH_W-1:0]        s1_other_ff;

   assign in_ready = !s1_ctl_ff.valid || prod_ready;

   always_comb begin
      s1_ctl_in = s1_ctl_ff;
      if (in_ready) begin
         s1_ctl_in.valid = in_valid;
         s1_ctl_in.kind  = in_kind;
         s1_ctl_in.last  = in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         pt_x_ff     <= in_pt_x;
         pt_y_ff     <= in_pt_y;
         s1_other_ff <= in_other;
      end
   end

   assign prod_ctl   = s1_ctl_ff;
   assign prod_00    = PROD_W'(rot_00) * PROD_W'(pt_x_ff);
   assign prod_01    = PROD_W'(rot_01) * PROD_W'(pt_y_ff);
   assign prod_10    = PROD_W'(rot_10) * PROD_W'(pt_x_ff);
   assign prod_11    = PROD_W'(rot_11) * PROD_W'(pt_y_ff);
   assign prod_other = s1_other_ff;

endmodule
`default_nettype wire

>>> rtl/rabb_box.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rabb_box
// Sum, floor shift and saturate the products, fold into the running box,
// commit on the last point, answer queries, and hold the result register.
// ----------------------------------------------------------------------------
module rabb_box import rabb_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   localparam int OW        = COORD_BITS + 1,
   localparam int OTH_W     = 4 * OW
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pipe_ctl_type                 ctl,
   input  logic signed [PROD_W-1:0]     prod_00,
   input  logic signed [PROD_W-1:0]     prod_01,
   input  logic signed [PROD_W-1:0]     prod_10,
   input  logic signed [PROD_W-1:0]     prod_11,
   input  logic [OTH_W-1:0]             other,
   input  logic signed [PT_W-1:0]       pos_x,
   input  logic signed [PT_W-1:0]       pos_y,
   output logic                         box_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output item_kind_type                rsp_kind,
   output logic signed [COORD_BITS-1:0] rsp_min_x,
   output logic signed [COORD_BITS-1:0] rsp_min_y,
   output logic signed [COORD_BITS-1:0] rsp_max_x,
   output logic signed [COORD_BITS-1:0] rsp_max_y,
   output logic                         rsp_overlap
);

   localparam int CMP_W = ((COORD_BITS > PT_W) ? COORD_BITS : PT_W) + 2;
   localparam logic signed [SUM_W-1:0] SAT_HI =
      {{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;
   localparam logic signed [COORD_BITS-1:0] EMPTY_LO = SAT_HI[COORD_BITS-1:0];
   localparam logic signed [COORD_BITS-1:0] EMPTY_HI = SAT_LO[COORD_BITS-1:0];

   logic signed [SUM_W-1:0]      sum_x, sum_y, shr_x, shr_y;
   logic signed [COORD_BITS-1:0] rx, ry;
   logic signed [COORD_BITS-1:0] nmin_x, nmin_y, nmax_x, nmax_y;

   logic signed [COORD_BITS-1:0] acc_min_x_ff, acc_min_y_ff, acc_max_x_ff, acc_max_y_ff;
   logic signed [COORD_BITS-1:0] acc_min_x_in, acc_min_y_in, acc_max_x_in, acc_max_y_in;
   logic signed [COORD_BITS-1:0] box_lo_x_ff, box_lo_y_ff, box_hi_x_ff, box_hi_y_ff;
   logic signed [COORD_BITS-1:0] box_lo_x_in, box_lo_y_in, box_hi_x_in, box_hi_y_in;
   logic                         box_valid_ff, box_valid_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   item_kind_type                rsp_kind_ff, rsp_kind_in;
   logic signed [COORD_BITS-1:0] rsp_min_x_ff, rsp_min_y_ff, rsp_max_x_ff, rsp_max_y_ff;
   logic signed [COORD_BITS-1:0] rsp_min_x_in, rsp_min_y_in, rsp_max_x_in, rsp_max_y_in;
   logic                         rsp_overlap_ff, rsp_overlap_in;

   logic signed [OW-1:0]         oth_min_x, oth_min_y, oth_max_x, oth_max_y;
   logic signed [CMP_W-1:0]      a_min_x, a_min_y, a_max_x, a_max_y;
   logic signed [CMP_W-1:0]      b_min_x, b_min_y, b_max_x, b_max_y;
   logic                         hit;
   logic                         take;

   assign box_ready = !rsp_valid_ff || rsp_ready;
   assign take      = ctl.valid && box_ready;

   // floor shift, then clamp to the coordinate range
   assign sum_x = SUM_W'(prod_00) + SUM_W'(prod_01);
   assign sum_y = SUM_W'(prod_10) + SUM_W'(prod_11);
   assign shr_x = sum_x >>> FRAC_BITS;
   assign shr_y = sum_y >>> FRAC_BITS;

   always_comb begin
      if (shr_x > SAT_HI) begin
         rx = EMPTY_LO;
      end else if (shr_x < SAT_LO) begin
         rx = EMPTY_HI;
      end else begin
         rx = shr_x[COORD_BITS-1:0];
      end
      if (shr_y > SAT_HI) begin
         ry = EMPTY_LO;
      end else if (shr_y < SAT_LO) begin
         ry = EMPTY_HI;
      end else begin
         ry = shr_y[COORD_BITS-1:0];
      end
   end

   assign nmin_x = (rx < acc_min_x_ff) ? rx : acc_min_x_ff;
   assign nmin_y = (ry < acc_min_y_ff) ? ry : acc_min_y_ff;
   assign nmax_x = (rx > acc_max_x_ff) ? rx : acc_max_x_ff;
   assign nmax_y = (ry > acc_max_y_ff) ? ry : acc_max_y_ff;

   assign oth_min_x = other[OW-1:0];
   assign oth_min_y = other[2*OW-1:OW];
   assign oth_max_x = other[3*OW-1:2*OW];
   assign oth_max_y = other[4*OW-1:3*OW];

   assign a_min_x = CMP_W'(box_lo_x_ff) + CMP_W'(pos_x);
   assign a_min_y = CMP_W'(box_lo_y_ff) + CMP_W'(pos_y);
   assign a_max_x = CMP_W'(box_hi_x_ff) + CMP_W'(pos_x);
   assign a_max_y = CMP_W'(box_hi_y_ff) + CMP_W'(pos_y);
   assign b_min_x = CMP_W'(oth_min_x);
   assign b_min_y = CMP_W'(oth_min_y);
   assign b_max_x = CMP_W'(oth_max_x);
   assign b_max_y = CMP_W'(oth_max_y);

   assign hit = box_valid_ff && (a_min_x <= b_max_x) && (b_min_x <= a_max_x)
                && (a_min_y <= b_max_y) && (b_min_y <= a_max_y);

   always_comb begin
      acc_min_x_in   = acc_min_x_ff;
      acc_min_y_in   = acc_min_y_ff;
      acc_max_x_in   = acc_max_x_ff;
      acc_max_y_in   = acc_max_y_ff;
      box_lo_x_in    = box_lo_x_ff;
      box_lo_y_in    = box_lo_y_ff;
      box_hi_x_in    = box_hi_x_ff;
      box_hi_y_in    = box_hi_y_ff;
      box_valid_in   = box_valid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_min_x_in   = rsp_min_x_ff;
      rsp_min_y_in   = rsp_min_y_ff;
      rsp_max_x_in   = rsp_max_x_ff;
      rsp_max_y_in   = rsp_max_y_ff;
      rsp_overlap_in = rsp_overlap_ff;
      if (take) begin
         if (ctl.kind == KIND_QUERY) begin
            rsp_valid_in   = 1'b1;
            rsp_kind_in    = KIND_QUERY;
            rsp_min_x_in   = '0;
            rsp_min_y_in   = '0;
            rsp_max_x_in   = '0;
            rsp_max_y_in   = '0;
            rsp_overlap_in = hit;
         end else if (ctl.last) begin
            box_lo_x_in    = nmin_x;
            box_lo_y_in    = nmin_y;
            box_hi_x_in    = nmax_x;
            box_hi_y_in    = nmax_y;
            box_valid_in   = 1'b1;
            acc_min_x_in   = EMPTY_LO;
            acc_min_y_in   = EMPTY_LO;
            acc_max_x_in   = EMPTY_HI;
            acc_max_y_in   = EMPTY_HI;
            rsp_valid_in   = 1'b1;
            rsp_kind_in    = KIND_POINT;
            rsp_min_x_in   = nmin_x;
            rsp_min_y_in   = nmin_y;
            rsp_max_x_in   = nmax_x;
            rsp_max_y_in   = nmax_y;
            rsp_overlap_in = 1'b0;
         end else begin
            acc_min_x_in   = nmin_x;
            acc_min_y_in   = nmin_y;
            acc_max_x_in   = nmax_x;
            acc_max_y_in   = nmax_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_min_x_ff <= EMPTY_LO;
         acc_min_y_ff <= EMPTY_LO;
         acc_max_x_ff <= EMPTY_HI;
         acc_max_y_ff <= EMPTY_HI;
         box_lo_x_ff  <= EMPTY_LO;
         box_lo_y_ff  <= EMPTY_LO;
         box_hi_x_ff  <= EMPTY_HI;
         box_hi_y_ff  <= EMPTY_HI;
         box_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_min_x_ff <= acc_min_x_in;
         acc_min_y_ff <= acc_min_y_in;
         acc_max_x_ff <= acc_max_x_in;
         acc_max_y_ff <= acc_max_y_in;
         box_lo_x_ff  <= box_lo_x_in;
         box_lo_y_ff  <= box_lo_y_in;
         box_hi_x_ff  <= box_hi_x_in;
         box_hi_y_ff  <= box_hi_y_in;
         box_valid_ff <= box_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff    <= rsp_kind_in;
      rsp_min_x_ff   <= rsp_min_x_in;
      rsp_min_y_ff   <= rsp_min_y_in;
      rsp_max_x_ff   <= rsp_max_x_in;
      rsp_max_y_ff   <= rsp_max_y_in;
      rsp_overlap_ff <= rsp_overlap_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_min_x   = rsp_min_x_ff;
   assign rsp_min_y   = rsp_min_y_ff;
   assign rsp_max_x   = rsp_max_x_ff;
   assign rsp_max_y   = rsp_max_y_ff;
   assign rsp_overlap = rsp_overlap_ff;

endmodule
`default_nettype wire

>>> rtl/rotated_aabb_build_and_overlap_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_aabb_build_and_overlap_core
// Rotates a stream of 2D points, builds their bounding box, commits it on the
// last point, and tests it against query boxes for overlap.
//
// Channel  Side    Carries
// req_*    slave   point (pt_x, pt_y, last) or query box (other min/max)
// rsp_*    master  committed box or overlap answer
// csr_*    APB     rot_00 rot_01 rot_10 rot_11 pos_x pos_y at 4*index
//
// One beat per cycle while rsp_tready keeps up; a req beat passes the input
// register, then the box/result register, on its way to a rsp beat.
// Reset loads the identity matrix, a zero offset and an empty box.
// A stalled rsp backs up through the two registers; req_tready drops only
// when both hold a beat and rsp_tready is low.
// ----------------------------------------------------------------------------
module rotated_aabb_build_and_overlap_core import rabb_pkg::*; #(
   parameter int COORD_BITS  = COORD_BITS_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   localparam int OTH_W      = 4 * (COORD_BITS + 1),
   localparam int IN_BITS    = 2 * PT_W + OTH_W,
   localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8,
   localparam int OUT_BITS   = 4 * COORD_BITS + 1,
   localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // pt_x, pt_y, other_min_x, other_min_y, other_max_x, other_max_y
   input  logic [IN_TDATA_W-1:0]  req_tdata,
   // kind
   input  logic                   req_tuser,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // box_min_x, box_min_y, box_max_x, box_max_y, overlap
   output logic [OUT_TDATA_W-1:0] rsp_tdata,
   // result_kind
   output logic                   rsp_tuser,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic signed [ROT_W-1:0]      rot_00, rot_01, rot_10, rot_11;
   logic signed [PT_W-1:0]       pos_x, pos_y;
   pipe_ctl_type                 prod_ctl;
   logic signed [PROD_W-1:0]     prod_00, prod_01, prod_10, prod_11;
   logic [OTH_W-1:0]             prod_other;
   logic                         prod_ready;
   item_kind_type                rsp_kind;
   logic signed [COORD_BITS-1:0] rsp_min_x, rsp_min_y, rsp_max_x, rsp_max_y;
   logic                         rsp_overlap;

   rabb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .rot_00      (rot_00),
      .rot_01      (rot_01),
      .rot_10      (rot_10),
      .rot_11      (rot_11),
      .pos_x       (pos_x),
      .pos_y       (pos_y)
   );

   rabb_rotate #(.COORD_BITS(COORD_BITS)) u_rotate (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_kind    (item_kind_type'(req_tuser)),
      .in_last    (req_tlast),
      .in_pt_x    (req_tdata[PT_W-1:0]),
      .in_pt_y    (req_tdata[2*PT_W-1:PT_W]),
      .in_other   (req_tdata[IN_BITS-1:2*PT_W]),
      .rot_00     (rot_00),
      .rot_01     (rot_01),
      .rot_10     (rot_10),
      .rot_11     (rot_11),
      .prod_ready (prod_ready),
      .prod_ctl   (prod_ctl),
      .prod_00    (prod_00),
      .prod_01    (prod_01),
      .prod_10    (prod_10),
      .prod_11    (prod_11),
      .prod_other (prod_other)
   );

   rabb_box #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_box (
      .clock       (clock),
      .reset       (reset),
      .ctl         (prod_ctl),
      .prod_00     (prod_00),
      .prod_01     (prod_01),
      .prod_10     (prod_10),
      .prod_11     (prod_11),
      .other       (prod_other),
      .pos_x       (pos_x),
      .pos_y       (pos_y),
      .box_ready   (prod_ready),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_kind    (rsp_kind),
      .rsp_min_x   (rsp_min_x),
      .rsp_min_y   (rsp_min_y),
      .rsp_max_x   (rsp_max_x),
      .rsp_max_y   (rsp_max_y),
      .rsp_overlap (rsp_overlap)
   );

   assign rsp_tuser = rsp_kind;
   assign rsp_tdata = OUT_TDATA_W'({rsp_overlap, rsp_max_y, rsp_max_x, rsp_min_y, rsp_min_x});

   a_box_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_POINT) |-> !rsp_tdata[4*COORD_BITS])
      else $error("committed box beat carries overlap");

   a_query_zero_box: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_QUERY) |-> rsp_tdata[4*COORD_BITS-1:0] == '0)
      else $error("overlap beat carries box fields");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("req stalled while result path free");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat right after reset");

endmodule
`default_nettype wire

>>> tb/rotated_aabb_build_and_overlap_core_tb.sv
// ----------------------------------------------------------------------------
// rotated_aabb_build_and_overlap_core_tb
// Self-checking bench for the rotated bounding box core. A directed table
// covers field extremes, saturation, rounding, edge contact and ignored
// register writes. Random phases follow, mostly point runs closed by a last
// beat and then queries placed around the committed world box. Idling on
// both channels varies per phase, and one phase holds the result channel
// off for a long stretch. Every result beat is compared with the value given in
// its table row or with an in-bench fixed point prediction of the box and overlap logic.
// ----------------------------------------------------------------------------
module rotated_aabb_build_and_overlap_core_tb;
   import rabb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  CLK_PERIOD    = 10;
   localparam int  CW            = COORD_BITS_DEF;
   localparam int  OW            = CW + 1;
   localparam int  IN_BITS       = 2 * PT_W + 4 * OW;
   localparam int  REQ_W         = ((IN_BITS + 7) / 8) * 8;
   localparam int  RSP_W         = ((4 * CW + 1 + 7) / 8) * 8;
   localparam int  PX_LSB        = 0;
   localparam int  PY_LSB        = PT_W;
   localparam int  OMINX_LSB     = 2 * PT_W;
   localparam int  OMINY_LSB     = OMINX_LSB + OW;
   localparam int  OMAXX_LSB     = OMINY_LSB + OW;
   localparam int  OMAXY_LSB     = OMAXX_LSB + OW;
   localparam int  NUM_REGS      = 6;
   localparam int  NUM_DIR       = 25;
   localparam int  NUM_PHASES    = 6;
   localparam int  PHASE_ITEMS   = 100;
   localparam int  PRESSURE_PH   = 4;
   localparam int  HOLDOFF       = 300;
   localparam int  SETTLE_CYCLES = 8;
   localparam int  STALL_LIMIT   = 3000;
   localparam longint COORD_MAX  = (longint'(1) << (CW - 1)) - 1;
   localparam longint COORD_MIN  = -(longint'(1) << (CW - 1));
   localparam longint OTH_MAX    = (longint'(1) << (OW - 1)) - 1;
   localparam longint OTH_MIN    = -(longint'(1) << (OW - 1));

   typedef enum logic { ROW_BEAT, ROW_CSR } row_op_type;

   typedef struct packed {
      item_kind_type       kind;
      logic signed [CW-1:0] min_x;
      logic signed [CW-1:0] min_y;
      logic signed [CW-1:0] max_x;
      logic signed [CW-1:0] max_y;
      logic                overlap;
   } box_result_type;

   typedef struct packed {
      row_op_type          op;
      item_kind_type       kind;
      logic                last;
      logic [PT_W-1:0]     pt_x;
      logic [PT_W-1:0]     pt_y;
      logic [OW-1:0]       oth_min_x;
      logic [OW-1:0]       oth_min_y;
      logic [OW-1:0]       oth_max_x;
      logic [OW-1:0]       oth_max_y;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [31:0]         reg_data;
      logic                typed;
      box_result_type      result;
   } dir_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata;
   logic                   req_tuser;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   logic signed [CW-1:0]   cfg_value [NUM_REGS];
   logic signed [CW-1:0]   acc_lo_x, acc_lo_y, acc_hi_x, acc_hi_y;
   logic signed [CW-1:0]   commit_lo_x, commit_lo_y, commit_hi_x, commit_hi_y;
   logic                   commit_valid;

   box_result_type         expected_answers [$];
   dir_row_type            dir_rows [NUM_DIR];
   int                     mismatches;
   int                     send_idle_pct;
   int                     rcv_stall_pct;
   int                     holdoff_cycles;
   int                     idle_cycles;

   rotated_aabb_build_and_overlap_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic [REQ_W-1:0] pack_req(input logic [PT_W-1:0] px, py,
                                                 input logic [OW-1:0] a, b, c, d);
      logic [REQ_W-1:0] v;
      v = '0;
      v[PX_LSB +: PT_W]  = px;
      v[PY_LSB +: PT_W]  = py;
      v[OMINX_LSB +: OW] = a;
      v[OMINY_LSB +: OW] = b;
      v[OMAXX_LSB +: OW] = c;
      v[OMAXY_LSB +: OW] = d;
      return v;
   endfunction

   function automatic logic signed [CW-1:0] rotate_axis_q(input logic signed [15:0] a, b,
                                                          input logic signed [15:0] x, y);
      longint sum;
      longint q;
      sum = longint'(a) * longint'(x) + longint'(b) * longint'(y);
      q   = sum >>> FRAC_BITS_DEF;
      if (q > COORD_MAX) q = COORD_MAX;
      if (q < COORD_MIN) q = COORD_MIN;
      return q[CW-1:0];
   endfunction

   function automatic void empty_accumulator();
      acc_lo_x = COORD_MAX[CW-1:0];
      acc_lo_y = COORD_MAX[CW-1:0];
      acc_hi_x = COORD_MIN[CW-1:0];
      acc_hi_y = COORD_MIN[CW-1:0];
   endfunction

   function automatic bit predict_box_step(input item_kind_type kind, input logic last,
                                           input logic [REQ_W-1:0] data,
                                           output box_result_type res);
      logic signed [15:0]   px, py;
      logic signed [CW-1:0] rx, ry;
      logic signed [OW-1:0] bminx, bminy, bmaxx, bmaxy;
      longint               aminx, aminy, amaxx, amaxy;
      res = '0;
      if (kind == KIND_POINT) begin
         px = data[PX_LSB +: PT_W];
         py = data[PY_LSB +: PT_W];
         rx = rotate_axis_q(cfg_value[REG_ROT_00], cfg_value[REG_ROT_01], px, py);
         ry = rotate_axis_q(cfg_value[REG_ROT_10], cfg_value[REG_ROT_11], px, py);
         if (rx < acc_lo_x) acc_lo_x = rx;
         if (ry < acc_lo_y) acc_lo_y = ry;
         if (rx > acc_hi_x) acc_hi_x = rx;
         if (ry > acc_hi_y) acc_hi_y = ry;
         if (!last) return 1'b0;
         commit_lo_x  = acc_lo_x;
         commit_lo_y  = acc_lo_y;
         commit_hi_x  = acc_hi_x;
         commit_hi_y  = acc_hi_y;
         commit_valid = 1'b1;
         empty_accumulator();
         res.kind  = KIND_POINT;
         res.min_x = commit_lo_x;
         res.min_y = commit_lo_y;
         res.max_x = commit_hi_x;
         res.max_y = commit_hi_y;
         return 1'b1;
      end
      bminx = data[OMINX_LSB +: OW];
      bminy = data[OMINY_LSB +: OW];
      bmaxx = data[OMAXX_LSB +: OW];
      bmaxy = data[OMAXY_LSB +: OW];
      aminx = longint'(commit_lo_x) + longint'(cfg_value[REG_POS_X]);
      aminy = longint'(commit_lo_y) + longint'(cfg_value[REG_POS_Y]);
      amaxx = longint'(commit_hi_x) + longint'(cfg_value[REG_POS_X]);
      amaxy = longint'(commit_hi_y) + longint'(cfg_value[REG_POS_Y]);
      res.kind    = KIND_QUERY;
      res.overlap = commit_valid &&
                    aminx <= longint'(bmaxx) && longint'(bminx) <= amaxx &&
                    aminy <= longint'(bmaxy) && longint'(bminy) <= amaxy;
      return 1'b1;
   endfunction

   function automatic dir_row_type pt_row(input logic last, input int x, input int y);
      dir_row_type r;
      r           = '0;
      r.op        = ROW_BEAT;
      r.kind      = KIND_POINT;
      r.last      = last;
      r.pt_x      = PT_W'(x);
      r.pt_y      = PT_W'(y);
      r.oth_min_x = OW'($urandom);
      r.oth_min_y = OW'($urandom);
      r.oth_max_x = OW'($urandom);
      r.oth_max_y = OW'($urandom);
      return r;
   endfunction

   function automatic dir_row_type qry_row(input int minx, miny, maxx, maxy);
      dir_row_type r;
      r           = '0;
      r.op        = ROW_BEAT;
      r.kind      = KIND_QUERY;
      r.last      = 1'($urandom_range(1));
      r.pt_x      = PT_W'($urandom);
      r.pt_y      = PT_W'($urandom);
      r.oth_min_x = OW'(minx);
      r.oth_min_y = OW'(miny);
      r.oth_max_x = OW'(maxx);
      r.oth_max_y = OW'(maxy);
      return r;
   endfunction

   function automatic dir_row_type reg_row(input int idx, input logic [31:0] data);
      dir_row_type r;
      r          = '0;
      r.op       = ROW_CSR;
      r.reg_idx  = CSR_IDX_W'(idx);
      r.reg_data = data;
      return r;
   endfunction

   function automatic dir_row_type with_box(input dir_row_type r,
                                            input int minx, miny, maxx, maxy);
      r.typed        = 1'b1;
      r.result       = '0;
      r.result.kind  = KIND_POINT;
      r.result.min_x = CW'(minx);
      r.result.min_y = CW'(miny);
      r.result.max_x = CW'(maxx);
      r.result.max_y = CW'(maxy);
      return r;
   endfunction

   function automatic dir_row_type with_hit(input dir_row_type r, input logic hit);
      r.typed          = 1'b1;
      r.result         = '0;
      r.result.kind    = KIND_QUERY;
      r.result.overlap = hit;
      return r;
   endfunction

   function automatic logic [PT_W-1:0] rand_coord();
      case ($urandom_range(3))
         0:       return PT_W'($urandom_range(0, 1023) - 512);
         1:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         default: return PT_W'($urandom);
      endcase
   endfunction

   function automatic logic [OW-1:0] clamp_oth(input longint v);
      if (v > OTH_MAX) v = OTH_MAX;
      if (v < OTH_MIN) v = OTH_MIN;
      return v[OW-1:0];
   endfunction

   task automatic pick_axis(input longint lo, hi, output logic [OW-1:0] omin, omax);
      longint               d1, d2, mn, mx;
      logic signed [OW-1:0] r1, r2;
      d1 = longint'($urandom_range(4)) - 2;
      d2 = longint'($urandom_range(4)) - 2;
      r1 = OW'($urandom);
      r2 = OW'($urandom);
      case ($urandom_range(3))
         0: begin
            mn = hi + d1;
            mx = mn + longint'($urandom_range(2000));
         end
         1: begin
            mx = lo + d1;
            mn = mx - longint'($urandom_range(2000));
         end
         2: begin
            mn = lo + d1;
            mx = hi + d2;
         end
         default: begin
            mn = r1;
            mx = r2;
         end
      endcase
      omin = clamp_oth(mn);
      omax = clamp_oth(mx);
   endtask

   task automatic rand_query_data(output logic [REQ_W-1:0] data);
      logic [OW-1:0] ominx, omaxx, ominy, omaxy;
      pick_axis(longint'(commit_lo_x) + longint'(cfg_value[REG_POS_X]),
                longint'(commit_hi_x) + longint'(cfg_value[REG_POS_X]), ominx, omaxx);
      pick_axis(longint'(commit_lo_y) + longint'(cfg_value[REG_POS_Y]),
                longint'(commit_hi_y) + longint'(cfg_value[REG_POS_Y]), ominy, omaxy);
      data = pack_req(PT_W'($urandom), PT_W'($urandom), ominx, ominy, omaxx, omaxy);
   endtask

   task automatic send_beat(input item_kind_type kind, input logic last,
                            input logic [REQ_W-1:0] data,
                            input logic typed, input box_result_type typed_res);
      box_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = data;
      req_tuser  = kind;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      if (predict_box_step(kind, last, data, res))
         expected_answers.push_back(typed ? typed_res : res);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic csr_write(input int idx, input logic [31:0] data);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_ADDR_W'(idx * 4);
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx < NUM_REGS) cfg_value[idx] = data[CW-1:0];
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic quiesce();
      while (expected_answers.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic check_field(input string name, input longint expv, input longint actv);
      if (expv != actv) begin
         $display("%0t %s expected %0d actual %0d", $time, name, expv, actv);
         mismatches++;
      end
   endtask

   // result channel ready, with a counted hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_cycles > 0) begin
            rsp_tready = 1'b0;
            holdoff_cycles--;
         end else begin
            rsp_tready = ($urandom_range(99) >= rcv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      box_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_answers.size() == 0) begin
            $display("%0t unexpected result beat tuser %0b tdata %h",
                     $time, rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = expected_answers.pop_front();
            check_field("result_kind", want.kind, rsp_tuser);
            check_field("box_min_x", $signed(want.min_x), $signed(rsp_tdata[0 +: CW]));
            check_field("box_min_y", $signed(want.min_y), $signed(rsp_tdata[CW +: CW]));
            check_field("box_max_x", $signed(want.max_x), $signed(rsp_tdata[2*CW +: CW]));
            check_field("box_max_y", $signed(want.max_y), $signed(rsp_tdata[3*CW +: CW]));
            check_field("overlap", want.overlap, rsp_tdata[4*CW]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      dir_row_type      row;
      logic [REQ_W-1:0] data;
      logic [31:0]      val;
      int               sent;
      int               n;
      bit               paused;

      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = KIND_POINT;
      req_tlast      = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      mismatches     = 0;
      send_idle_pct  = 0;
      rcv_stall_pct  = 0;
      holdoff_cycles = 0;
      idle_cycles    = 0;

      cfg_value[REG_ROT_00] = ROT_ONE;
      cfg_value[REG_ROT_01] = '0;
      cfg_value[REG_ROT_10] = '0;
      cfg_value[REG_ROT_11] = ROT_ONE;
      cfg_value[REG_POS_X]  = '0;
      cfg_value[REG_POS_Y]  = '0;
      empty_accumulator();
      commit_lo_x  = COORD_MAX[CW-1:0];
      commit_lo_y  = COORD_MAX[CW-1:0];
      commit_hi_x  = COORD_MIN[CW-1:0];
      commit_hi_y  = COORD_MIN[CW-1:0];
      commit_valid = 1'b0;

      dir_rows[0]  = with_hit(qry_row(-65536, -65536, 65535, 65535), 1'b0);
      dir_rows[1]  = with_box(pt_row(1'b1, 0, 0), 0, 0, 0, 0);
      dir_rows[2]  = with_hit(qry_row(0, 0, 0, 0), 1'b1);
      dir_rows[3]  = with_hit(qry_row(1, 1, 5, 5), 1'b0);
      dir_rows[4]  = qry_row(5, 5, -5, -5);
      dir_rows[5]  = pt_row(1'b0, 32767, -32768);
      dir_rows[6]  = with_box(pt_row(1'b1, -32768, 32767), -32768, -32768, 32767, 32767);
      dir_rows[7]  = with_hit(qry_row(-65536, -65536, 65535, 65535), 1'b1);
      dir_rows[8]  = qry_row(32767, 32767, 40000, 40000);
      dir_rows[9]  = reg_row(REG_POS_X, 32'h0000_7FFF);
      dir_rows[10] = reg_row(REG_POS_Y, 32'hFFFF_8000);
      dir_rows[11] = qry_row(65534, -65536, 65535, -65536);
      dir_rows[12] = qry_row(65535, -65536, 65535, -65536);
      dir_rows[13] = reg_row(REG_ROT_00, 32'h0000_8000);
      dir_rows[14] = reg_row(REG_ROT_01, 32'h0000_8000);
      dir_rows[15] = reg_row(REG_ROT_10, 32'h0000_7FFF);
      dir_rows[16] = reg_row(REG_ROT_11, 32'h0000_8000);
      dir_rows[17] = reg_row(NUM_REGS, 32'h0000_1234);
      dir_rows[18] = reg_row(NUM_REGS + 1, 32'hFFFF_FFFF);
      dir_rows[19] = pt_row(1'b1, -32768, -32768);
      dir_rows[20] = pt_row(1'b0, -1, 0);
      dir_rows[21] = pt_row(1'b1, 1, -1);
      dir_rows[22] = pt_row(1'b1, 32767, 32767);
      dir_rows[23] = qry_row(-65536, -65536, 65535, 65535);
      dir_rows[24] = qry_row(-65536, -65536, -65536, -65536);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < NUM_DIR; i++) begin
         row = dir_rows[i];
         if (row.op == ROW_CSR) begin
            quiesce();
            csr_write(row.reg_idx, row.reg_data);
         end else begin
            send_beat(row.kind, row.last,
                      pack_req(row.pt_x, row.pt_y, row.oth_min_x, row.oth_min_y,
                               row.oth_max_x, row.oth_max_y),
                      row.typed, row.result);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         quiesce();
         for (int r = 0; r < NUM_REGS; r++) begin
            case (ph % 3)
               0: begin
                  if (r == REG_ROT_00 || r == REG_ROT_11) val = 32'(ROT_ONE);
                  else if (r == REG_ROT_01 || r == REG_ROT_10) val = '0;
                  else val = $urandom;
               end
               1: val = $urandom;
               default: begin
                  case ($urandom_range(4))
                     0:       val = 32'h0000_8000;
                     1:       val = 32'h0000_7FFF;
                     2:       val = '0;
                     3:       val = 32'(ROT_ONE);
                     default: val = $urandom;
                  endcase
               end
            endcase
            csr_write(r, val);
         end
         csr_write(NUM_REGS + $urandom_range(1), $urandom);

         case (ph)
            1:       begin send_idle_pct = 70; rcv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rcv_stall_pct = 70; end
            3, 5:    begin send_idle_pct = 15; rcv_stall_pct = 15; end
            default: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
         endcase
         if (ph == PRESSURE_PH) holdoff_cycles = HOLDOFF;

         sent   = 0;
         paused = 1'b0;
         while (sent < PHASE_ITEMS) begin
            if (!paused && sent >= PHASE_ITEMS / 2) begin
               quiesce();
               paused = 1'b1;
            end
            if ($urandom_range(99) < 80) begin
               n = $urandom_range(1, 6);
               for (int k = 0; k < n; k++)
                  send_beat(KIND_POINT, k == n - 1,
                            pack_req(rand_coord(), rand_coord(),
                                     OW'($urandom), OW'($urandom),
                                     OW'($urandom), OW'($urandom)),
                            1'b0, '0);
               sent += n;
               n = $urandom_range(1, 3);
               for (int k = 0; k < n; k++) begin
                  rand_query_data(data);
                  send_beat(KIND_QUERY, 1'($urandom_range(1)), data, 1'b0, '0);
               end
               sent += n;
            end else begin
               data = REQ_W'({$urandom, $urandom, $urandom, $urandom});
               data[REQ_W-1:IN_BITS] = '0;
               send_beat(item_kind_type'($urandom_range(1)), 1'($urandom_range(1)),
                         data, 1'b0, '0);
               sent++;
            end
         end
      end

      while (expected_answers.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && expected_answers.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> sim.f
rtl/rabb_pkg.sv
rtl/rabb_csr.sv
rtl/rabb_rotate.sv
rtl/rabb_box.sv
rtl/rotated_aabb_build_and_overlap_core.sv
tb/rotated_aabb_build_and_overlap_core_tb.sv
